[hw/rtl/prq_pkg.sv]
// ----------------------------------------------------------------------------
// prq_pkg
// Shared types and constants for the priority ready-queue scheduler: command
// and result transaction layouts, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package prq_pkg;

    localparam int DEF_NUM_LEVELS = 32;
    localparam int DEF_NUM_TASKS  = 32;

    // Fixed widths of the task and level fields on the ports.
    localparam int ID_W  = 5;
    localparam int LVL_W = 5;

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_POP     = 2'd1,
        OP_REMOVE  = 2'd2,
        OP_QUERY   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_UNQUEUED  = 2'd2
    } status_t;

    typedef struct packed {
        op_t              op;
        logic [ID_W-1:0]  task_id;
        logic [LVL_W-1:0] priority_req;
    } cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]  popped_task;
        logic             popped_valid;
        logic             any_ready;
        logic [LVL_W-1:0] best_level;
        logic [ID_W-1:0]  best_head_task;
        logic             level_has_peer;
        status_t          status;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENQ_RD,
        S_ENQ_WR,
        S_ENQ_LINK,
        S_POP_RD,
        S_POP_TSK,
        S_TSK_RD,
        S_UNLINK,
        S_UNLINK2,
        S_REPORT,
        S_DONE
    } state_t;

endpackage

[hw/rtl/priority_ready_queue_bitmap.sv]
// ----------------------------------------------------------------------------
// priority_ready_queue_bitmap
// A command steps through the sequencer states; query and ignored commands
// go straight to report. Enqueue reads the level, writes the task and links
// the old tail; pop reads the best level and its head, then pop and remove
// unlink the task. The path is set by the chain of dependent reads and writes on the task link memory.
// Reset clears the level bitmap, queued flags and link flags at once; the
// link and head/tail memories need no clearing pass. Results cannot stall.
// ----------------------------------------------------------------------------
module priority_ready_queue_bitmap #(
    parameter int NUM_LEVELS = prq_pkg::DEF_NUM_LEVELS,
    parameter int NUM_TASKS  = prq_pkg::DEF_NUM_TASKS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  prq_pkg::cmd_t    cmd,
    output logic             done,
    output prq_pkg::result_t result
);
    import prq_pkg::*;

    localparam int TID_W = $clog2(NUM_TASKS);
    localparam int LID_W = $clog2(NUM_LEVELS);

    typedef struct packed {
        logic [TID_W-1:0] succ_id;
        logic [TID_W-1:0] pred_id;
        logic [LID_W-1:0] level;
    } task_entry_t;

    typedef struct packed {
        logic [TID_W-1:0] head;
        logic [TID_W-1:0] tail;
    } level_entry_t;

    // Memories and their registered read data.
    task_entry_t  task_mem [NUM_TASKS];
    level_entry_t level_mem [NUM_LEVELS];
    task_entry_t  task_rd_reg;
    level_entry_t level_rd_a_reg;
    level_entry_t level_rd_b_reg;

    // Memory port controls.
    logic             tw_we_all;
    logic             tw_we_succ;
    logic             tw_we_pred;
    logic [TID_W-1:0] tw_addr;
    task_entry_t      tw_data;
    logic             tr_en;
    logic [TID_W-1:0] tr_addr;
    logic             lw_we_head;
    logic             lw_we_tail;
    logic [LID_W-1:0] lw_addr;
    level_entry_t     lw_data;
    logic             la_en;
    logic [LID_W-1:0] la_addr;
    logic             lb_en;
    logic [LID_W-1:0] lb_addr;

    // Control state.
    state_t                state_reg, state_next;
    logic [NUM_LEVELS-1:0] level_bitmap_reg, level_bitmap_next;
    logic [NUM_TASKS-1:0]  task_queued_reg, task_queued_next;
    logic [NUM_TASKS-1:0]  succ_ok_reg, succ_ok_next;
    logic [NUM_TASKS-1:0]  pred_ok_reg, pred_ok_next;
    logic                  done_reg;

    // Transaction payload.
    logic [LVL_W-1:0] preq_reg, preq_next;
    logic [TID_W-1:0] t_reg, t_next;
    logic [TID_W-1:0] popped_reg, popped_next;
    logic             pvalid_reg, pvalid_next;
    status_t          status_reg, status_next;
    result_t          result_reg, result_next;

    logic [LID_W-1:0] best_lvl;
    logic             any_ready;
    logic [TID_W-1:0] cmd_tid_idx;
    logic             cmd_tid_ok;
    logic             cmd_preq_ok;
    logic [LID_W-1:0] preq_idx;
    logic             preq_ok;

    assign any_ready   = |level_bitmap_reg;
    assign cmd_tid_idx = TID_W'(cmd.task_id);
    assign cmd_tid_ok  = 32'(cmd.task_id) < NUM_TASKS;
    assign cmd_preq_ok = 32'(cmd.priority_req) < NUM_LEVELS;
    assign preq_idx    = LID_W'(preq_reg);
    assign preq_ok     = 32'(preq_reg) < NUM_LEVELS;

    // Lowest-numbered non-empty level.
    always_comb
    begin
        best_lvl = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (level_bitmap_reg[i])
            begin
                best_lvl = LID_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tw_we_all)
        begin
            task_mem[tw_addr] <= tw_data;
        end
        else
        begin
            if (tw_we_succ)
            begin
                task_mem[tw_addr].succ_id <= tw_data.succ_id;
            end
            if (tw_we_pred)
            begin
                task_mem[tw_addr].pred_id <= tw_data.pred_id;
            end
        end
        if (tr_en)
        begin
            task_rd_reg <= task_mem[tr_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (lw_we_head)
        begin
            level_mem[lw_addr].head <= lw_data.head;
        end
        if (lw_we_tail)
        begin
            level_mem[lw_addr].tail <= lw_data.tail;
        end
        if (la_en)
        begin
            level_rd_a_reg <= level_mem[la_addr];
        end
        if (lb_en)
        begin
            level_rd_b_reg <= level_mem[lb_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            level_bitmap_reg <= '0;
            task_queued_reg  <= '0;
            succ_ok_reg      <= '0;
            pred_ok_reg      <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            level_bitmap_reg <= level_bitmap_next;
            task_queued_reg  <= task_queued_next;
            succ_ok_reg      <= succ_ok_next;
            pred_ok_reg      <= pred_ok_next;
            done_reg         <= (state_reg == S_DONE);
        end
    end

    always_ff @(posedge clk)
    begin
        preq_reg   <= preq_next;
        t_reg      <= t_next;
        popped_reg <= popped_next;
        pvalid_reg <= pvalid_next;
        status_reg <= status_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        level_bitmap_next = level_bitmap_reg;
        task_queued_next  = task_queued_reg;
        succ_ok_next      = succ_ok_reg;
        pred_ok_next      = pred_ok_reg;
        preq_next         = preq_reg;
        t_next            = t_reg;
        popped_next       = popped_reg;
        pvalid_next       = pvalid_reg;
        status_next       = status_reg;
        result_next       = result_reg;

        tw_we_all  = 1'b0;
        tw_we_succ = 1'b0;
        tw_we_pred = 1'b0;
        tw_addr    = '0;
        tw_data    = '0;
        tr_en      = 1'b0;
        tr_addr    = '0;
        lw_we_head = 1'b0;
        lw_we_tail = 1'b0;
        lw_addr    = '0;
        lw_data    = '0;
        la_en      = 1'b0;
        la_addr    = '0;
        lb_en      = 1'b0;
        lb_addr    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    preq_next   = cmd.priority_req;
                    t_next      = cmd_tid_idx;
                    popped_next = '0;
                    pvalid_next = 1'b0;
                    status_next = ST_OK;
                    state_next  = S_REPORT;
                    case (cmd.op)
                        OP_ENQUEUE:
                        begin
                            if (cmd_tid_ok && cmd_preq_ok)
                            begin
                                if (task_queued_reg[cmd_tid_idx])
                                begin
                                    status_next = ST_DUPLICATE;
                                end
                                else
                                begin
                                    state_next = S_ENQ_RD;
                                end
                            end
                        end
                        OP_POP:
                        begin
                            if (any_ready)
                            begin
                                state_next = S_POP_RD;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (cmd_tid_ok && task_queued_reg[cmd_tid_idx])
                            begin
                                state_next = S_TSK_RD;
                            end
                            else
                            begin
                                status_next = ST_UNQUEUED;
                            end
                        end
                        default:
                        begin
                            state_next = S_REPORT;
                        end
                    endcase
                end
            end

            S_ENQ_RD:
            begin
                la_en      = 1'b1;
                la_addr    = preq_idx;
                state_next = S_ENQ_WR;
            end

            S_ENQ_WR:
            begin
                // The current tail is only meaningful if the level is non-empty.
                tw_we_all       = 1'b1;
                tw_addr         = t_reg;
                tw_data.succ_id = '0;
                tw_data.pred_id = level_rd_a_reg.tail;
                tw_data.level   = preq_idx;
                lw_addr         = preq_idx;
                lw_we_head      = !level_bitmap_reg[preq_idx];
                lw_we_tail      = 1'b1;
                lw_data.head    = t_reg;
                lw_data.tail    = t_reg;
                task_queued_next[t_reg] = 1'b1;
                succ_ok_next[t_reg]     = 1'b0;
                pred_ok_next[t_reg]     = level_bitmap_reg[preq_idx];
                level_bitmap_next[preq_idx] = 1'b1;
                if (level_bitmap_reg[preq_idx])
                begin
                    succ_ok_next[level_rd_a_reg.tail] = 1'b1;
                    state_next = S_ENQ_LINK;
                end
                else
                begin
                    state_next = S_REPORT;
                end
            end

            S_ENQ_LINK:
            begin
                tw_we_succ      = 1'b1;
                tw_addr         = level_rd_a_reg.tail;
                tw_data.succ_id = t_reg;
                state_next      = S_REPORT;
            end

            S_POP_RD:
            begin
                la_en      = 1'b1;
                la_addr    = best_lvl;
                state_next = S_POP_TSK;
            end

            S_POP_TSK:
            begin
                t_next      = level_rd_a_reg.head;
                popped_next = level_rd_a_reg.head;
                pvalid_next = 1'b1;
                tr_en       = 1'b1;
                tr_addr     = level_rd_a_reg.head;
                state_next  = S_UNLINK;
            end

            S_TSK_RD:
            begin
                tr_en      = 1'b1;
                tr_addr    = t_reg;
                state_next = S_UNLINK;
            end

            S_UNLINK:
            begin
                // Predecessor link and head/tail fix-up; the successor's back
                // link is written in the following cycle.
                lw_addr = task_rd_reg.level;
                if (pred_ok_reg[t_reg])
                begin
                    tw_we_succ      = 1'b1;
                    tw_addr         = task_rd_reg.pred_id;
                    tw_data.succ_id = task_rd_reg.succ_id;
                    succ_ok_next[task_rd_reg.pred_id] = succ_ok_reg[t_reg];
                end
                else if (succ_ok_reg[t_reg])
                begin
                    lw_we_head   = 1'b1;
                    lw_data.head = task_rd_reg.succ_id;
                end
                if (succ_ok_reg[t_reg])
                begin
                    pred_ok_next[task_rd_reg.succ_id] = pred_ok_reg[t_reg];
                end
                else if (pred_ok_reg[t_reg])
                begin
                    lw_we_tail   = 1'b1;
                    lw_data.tail = task_rd_reg.pred_id;
                end
                if (!pred_ok_reg[t_reg] && !succ_ok_reg[t_reg])
                begin
                    level_bitmap_next[task_rd_reg.level] = 1'b0;
                end
                succ_ok_next[t_reg]     = 1'b0;
                pred_ok_next[t_reg]     = 1'b0;
                task_queued_next[t_reg] = 1'b0;
                state_next = succ_ok_reg[t_reg] ? S_UNLINK2 : S_REPORT;
            end

            S_UNLINK2:
            begin
                tw_we_pred      = 1'b1;
                tw_addr         = task_rd_reg.succ_id;
                tw_data.pred_id = task_rd_reg.pred_id;
                state_next      = S_REPORT;
            end

            S_REPORT:
            begin
                la_en      = 1'b1;
                la_addr    = best_lvl;
                lb_en      = 1'b1;
                lb_addr    = preq_idx;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                result_next.popped_task    = ID_W'(popped_reg);
                result_next.popped_valid   = pvalid_reg;
                result_next.any_ready      = any_ready;
                result_next.best_level     = any_ready ? LVL_W'(best_lvl) : '0;
                result_next.best_head_task = any_ready ? ID_W'(level_rd_a_reg.head) : '0;
                result_next.level_has_peer = preq_ok && level_bitmap_reg[preq_idx] &&
                                             (level_rd_b_reg.head != level_rd_b_reg.tail);
                result_next.status         = status_reg;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // Some level is marked non-empty exactly when some task is queued.
    a_bitmap_matches_queued: assert property (@(posedge clk) disable iff (!rst_n)
        ((level_bitmap_reg == '0) == (task_queued_reg == '0)))
        else $error("level bitmap and queued flags disagree");

    // Link flags only exist on queued tasks.
    a_succ_ok_queued: assert property (@(posedge clk) disable iff (!rst_n)
        ((succ_ok_reg & ~task_queued_reg) == '0))
        else $error("successor link on an unqueued task");

    a_pred_ok_queued: assert property (@(posedge clk) disable iff (!rst_n)
        ((pred_ok_reg & ~task_queued_reg) == '0))
        else $error("predecessor link on an unqueued task");

    // The strobe is registered and comes in the cycle after the final state of a transaction.
    a_done_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == S_DONE) && (state_reg == S_IDLE))
        else $error("result strobe outside the end of a transaction");

endmodule
